FILE: rtl/b64d_pkg.sv
// Package for the streaming base64 decoder: shared types, constants and
// the result structure passed from the accumulator to the top level. No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SymW   = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] CAP_RESET = 16'hFFFF;

  // Symbol value offsets for the lower-case and digit ranges, and the values of symbols 62 and 63.
  localparam logic [SymW-1:0] SYM_LOWER_BASE = 6'd26;
  localparam logic [SymW-1:0] SYM_DIGIT_BASE = 6'd52;
  localparam logic [SymW-1:0] SYM_PLUS       = 6'd62;
  localparam logic [SymW-1:0] SYM_SLASH      = 6'd63;

  // ASCII codes of the accepted characters.
  localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CharW-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [CharW-1:0] CH_DIGIT_9 = 8'h39;
  localparam logic [CharW-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CharW-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CharW-1:0] CH_UNDER   = 8'h5F;

  typedef struct packed {
    logic              byte_valid;
    logic [ByteW-1:0]  data_byte;
    logic              status;
    logic              message_done;
    logic [CountW-1:0] byte_count;
  } b64d_result_t;

  typedef struct packed {
    logic             hit;
    logic [SymW-1:0]  value;
  } b64d_sym_t;

endpackage

FILE: rtl/b64d_if.sv
// Valid/ready channel interfaces for the base64 decoder: character input,
// decoded byte output and the capacity configuration write. Uses b64d_pkg.
`timescale 1ns / 1ps

interface b64d_char_if;
  logic                         valid;
  logic                         ready;
  logic [b64d_pkg::CharW-1:0]   char_code;
  logic                         end_of_message;

  modport source (output valid, output char_code, output end_of_message, input ready);
  modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface b64d_byte_if;
  logic                         valid;
  logic                         ready;
  logic                         byte_valid;
  logic [b64d_pkg::ByteW-1:0]   data_byte;
  logic                         status;
  logic                         message_done;
  logic [b64d_pkg::CountW-1:0]  byte_count;

  modport source (output valid, output byte_valid, output data_byte, output status,
                  output message_done, output byte_count, input ready);
  modport sink   (input valid, input byte_valid, input data_byte, input status,
                  input message_done, input byte_count, output ready);
endinterface

interface b64d_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [b64d_pkg::CountW-1:0]  output_capacity;

  modport source (output valid, output output_capacity, input ready);
  modport sink   (input valid, input output_capacity, output ready);
endinterface

FILE: rtl/b64d_sym_map.sv
// Character to 6-bit symbol lookup for the base64 decoder.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_sym_map (
  input  logic [b64d_pkg::CharW-1:0] char_code,
  output b64d_pkg::b64d_sym_t        sym
);
  import b64d_pkg::*;

  always_comb begin
    sym.hit   = 1'b1;
    sym.value = '0;
    if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
      sym.value = SymW'(char_code - CH_UPPER_A);
    end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
      sym.value = SymW'(char_code - CH_LOWER_A) + SYM_LOWER_BASE;
    end else if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9) begin
      sym.value = SymW'(char_code - CH_DIGIT_0) + SYM_DIGIT_BASE;
    end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
      sym.value = SYM_PLUS;
    end else if (char_code == CH_SLASH || char_code == CH_UNDER) begin
      sym.value = SYM_SLASH;
    end else begin
      // Padding, whitespace and anything else carries no bits.
      sym.hit = 1'b0;
    end
  end

endmodule

FILE: rtl/b64d_accum.sv
// Bit accumulator and per-message byte counter of the base64 decoder.
// Holds the message state and forms one result per advancing word. Uses b64d_pkg.
`timescale 1ns / 1ps

module b64d_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  b64d_pkg::b64d_sym_t          sym,
  input  logic                         end_of_message,
  input  logic [b64d_pkg::CountW-1:0]  capacity,
  output b64d_pkg::b64d_result_t       result
);
  import b64d_pkg::*;

  logic [SymW-1:0]   pending_bits;
  logic [2:0]        pending_count;
  logic [CountW-1:0] bytes_out;
  logic              overflowed;

  logic [SymW-1:0]   pending_bits_next;
  logic [2:0]        pending_count_next;
  logic [CountW-1:0] bytes_out_next;
  logic              overflowed_next;

  logic [2*SymW-1:0] acc;
  logic [3:0]        cnt_full;
  logic [3:0]        cnt_left;
  logic              byte_done;
  logic [2*SymW-1:0] acc_shift;
  logic [SymW-1:0]   keep_mask;
  logic              emit;

  always_comb begin
    acc       = {pending_bits, sym.value};
    cnt_full  = 4'(pending_count) + 4'd6;
    byte_done = sym.hit && (cnt_full >= 4'd8);
    cnt_left  = cnt_full >= 4'd8 ? cnt_full - 4'd8 : cnt_full;
    acc_shift = acc >> cnt_left;
    keep_mask = SymW'((7'd1 << cnt_left[2:0]) - 7'd1);

    overflowed_next = overflowed || (byte_done && bytes_out >= capacity);
    emit            = byte_done && !overflowed_next;
    bytes_out_next  = bytes_out + CountW'(emit);

    pending_bits_next  = sym.hit ? (acc[SymW-1:0] & keep_mask) : pending_bits;
    pending_count_next = sym.hit ? cnt_left[2:0] : pending_count;

    result.byte_valid   = emit;
    result.data_byte    = emit ? acc_shift[ByteW-1:0] : '0;
    result.status       = overflowed_next;
    result.message_done = end_of_message;
    result.byte_count   = bytes_out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      bytes_out     <= '0;
      overflowed    <= 1'b0;
    end else if (advance) begin
      if (end_of_message) begin
        pending_bits  <= '0;
        pending_count <= '0;
        bytes_out     <= '0;
        overflowed    <= 1'b0;
      end else begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
        bytes_out     <= bytes_out_next;
        overflowed    <= overflowed_next;
      end
    end
  end

endmodule

FILE: rtl/base64_stream_decoder_unit.sv
// Top level of the streaming base64 decoder: input register, symbol lookup,
// accumulator and result register. Uses b64d_pkg, b64d_if, b64d_sym_map, b64d_accum.
`timescale 1ns / 1ps

// Channel   Role    Word carried
// -------   -----   ------------------------------------------------------------
// chars     sink    char_code, end_of_message: one character per word
// bytes     source  byte_valid, data_byte, status, message_done, byte_count
// cfg       sink    output_capacity: new per-message byte limit, always ready
//
// Every character word yields exactly one result word, and a new word can be
// taken every cycle while the output is not stalled. The rate is set by the
// loop through the accumulator state, which moves with each word: the lookup,
// shift and capacity compare all fit between the input register and
// the result register. When the result register is full and not taken, the
// input register holds its word and chars.ready drops only once both are full.
// The synchronous reset clears the message state, both valid flags and sets
// the capacity to its reset value of 65535.
module base64_stream_decoder_unit (
  input logic       clk,
  input logic       rst,
  b64d_char_if.sink chars,
  b64d_byte_if.source bytes,
  b64d_cfg_if.sink  cfg
);
  import b64d_pkg::*;

  // Input register stage.
  logic              in_valid;
  logic [CharW-1:0]  in_char;
  logic              in_eom;

  // Result register stage.
  logic              out_valid;
  b64d_result_t      out_result;

  logic [CountW-1:0] capacity;

  logic              advance;
  b64d_sym_t         sym;
  b64d_result_t      result;

  // The input word moves into the result register when that register is free
  // or is being emptied this cycle; the state of the message moves with it.
  assign advance     = in_valid && (!out_valid || bytes.ready);
  assign chars.ready = !in_valid || advance;
  assign cfg.ready   = 1'b1;

  b64d_sym_map u_sym_map (
    .char_code (in_char),
    .sym       (sym)
  );

  b64d_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .sym            (sym),
    .end_of_message (in_eom),
    .capacity       (capacity),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      capacity  <= CAP_RESET;
    end else begin
      if (chars.ready) begin
        in_valid <= chars.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (bytes.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        capacity <= cfg.output_capacity;
      end
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.char_code;
      in_eom  <= chars.end_of_message;
    end
    if (advance) begin
      out_result <= result;
    end
  end

  assign bytes.valid        = out_valid;
  assign bytes.byte_valid   = out_result.byte_valid;
  assign bytes.data_byte    = out_result.data_byte;
  assign bytes.status       = out_result.status;
  assign bytes.message_done = out_result.message_done;
  assign bytes.byte_count   = out_result.byte_count;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for base64_stream_decoder_unit: drives characters and
// capacity writes, predicts every result word and compares it. Uses b64d_pkg and b64d_if.
`timescale 1ns / 1ps

module tb;
  import b64d_pkg::*;

  // Characters that the decoder skips, used as filler and noise.
  localparam logic [CharW-1:0] CH_PAD   = 8'h3D;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;

  localparam int unsigned RANDOM_CHARS = 1450;
  localparam int unsigned STEADY_TAIL  = 150;   // final characters sent with no idling
  localparam int unsigned HOLD_CYCLES  = 60;    // long receiver hold-off
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int unsigned PRINT_LIMIT  = 30;

  // Expected result words and the decoder state that produces them. Every
  // accepted character word yields exactly one result word, so a plain FIFO of
  // predicted words lines up with the output stream.
  class decoded_word_checker;
    logic [CountW-1:0] capacity;
    logic [SymW-1:0]   carry_bits;
    logic [2:0]        carry_count;
    logic [CountW-1:0] msg_bytes;
    logic              msg_overflow;
    b64d_result_t      expected_words[$];
    int unsigned       errors;
    int unsigned       words_checked;
    int unsigned       bytes_decoded;
    int unsigned       overflow_words;
    int unsigned       messages;
    int unsigned       cap_writes;

    function new();
      capacity       = CAP_RESET;
      errors         = 0;
      words_checked  = 0;
      bytes_decoded  = 0;
      overflow_words = 0;
      messages       = 0;
      cap_writes     = 0;
      clear_message();
    endfunction

    function void clear_message();
      carry_bits   = '0;
      carry_count  = '0;
      msg_bytes    = '0;
      msg_overflow = 1'b0;
    endfunction

    function void set_capacity(logic [CountW-1:0] value);
      capacity = value;
      cap_writes++;
    endfunction

    function b64d_sym_t symbol_of(logic [CharW-1:0] ch);
      b64d_sym_t s;
      s.hit = 1'b1;
      s.value = '0;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
        s.value = SymW'(ch - CH_UPPER_A);
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
        s.value = SymW'(ch - CH_LOWER_A) + SYM_LOWER_BASE;
      end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
        s.value = SymW'(ch - CH_DIGIT_0) + SYM_DIGIT_BASE;
      end else if (ch == CH_PLUS || ch == CH_MINUS) begin
        s.value = SYM_PLUS;
      end else if (ch == CH_SLASH || ch == CH_UNDER) begin
        s.value = SYM_SLASH;
      end else begin
        s.hit = 1'b0;
      end
      return s;
    endfunction

    function void note_char(logic [CharW-1:0] ch, logic last);
      b64d_sym_t    s;
      b64d_result_t r;
      logic [11:0]  acc;
      logic [3:0]   cnt;
      logic [11:0]  keep_mask;
      r = '0;
      s = symbol_of(ch);
      if (s.hit) begin
        acc = {carry_bits, s.value};
        cnt = 4'(carry_count) + 4'd6;
        if (cnt >= 4'd8) begin
          cnt = cnt - 4'd8;
          // The capacity test uses the register value at this very word.
          if (!msg_overflow && msg_bytes >= capacity) msg_overflow = 1'b1;
          if (!msg_overflow) begin
            r.byte_valid = 1'b1;
            r.data_byte  = ByteW'(acc >> cnt);
            msg_bytes    = msg_bytes + 1'b1;
            bytes_decoded++;
          end
        end
        keep_mask   = (12'd1 << cnt) - 12'd1;
        carry_bits  = SymW'(acc & keep_mask);
        carry_count = cnt[2:0];
      end
      r.status       = msg_overflow;
      r.message_done = last;
      r.byte_count   = msg_bytes;
      if (msg_overflow) overflow_words++;
      expected_words.push_back(r);
      if (last) begin
        messages++;
        clear_message();
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("[%0t] MISMATCH word %0d %s: got 0x%0h expected 0x%0h",
                 $time, words_checked, what, got, want);
    endtask

    task check_word(b64d_result_t got);
      b64d_result_t want;
      if (expected_words.size() == 0) begin
        report("word with no character pending", got.data_byte, 0);
        return;
      end
      want = expected_words.pop_front();
      if (got.byte_valid !== want.byte_valid)
        report("byte_valid", got.byte_valid, want.byte_valid);
      if (got.data_byte !== want.data_byte)
        report("data_byte", got.data_byte, want.data_byte);
      if (got.status !== want.status)
        report("status", got.status, want.status);
      if (got.message_done !== want.message_done)
        report("message_done", got.message_done, want.message_done);
      if (got.byte_count !== want.byte_count)
        report("byte_count", got.byte_count, want.byte_count);
      words_checked++;
    endtask
  endclass

  logic clk;
  logic rst;

  b64d_char_if chars_if ();
  b64d_byte_if bytes_if ();
  b64d_cfg_if  cfg_if ();

  base64_stream_decoder_unit uut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if),
    .bytes (bytes_if),
    .cfg   (cfg_if)
  );

  decoded_word_checker word_check = new();

  // hold_req and steady are shared between the stimulus and the receiver. The
  // stimulus raises hold_req, and the receiver clears it once it starts the hold-off.
  bit          hold_req = 1'b0;
  bit          steady   = 1'b0;
  int unsigned chars_sent = 0;
  int unsigned tx_run_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // All handshakes are sampled at the rising edge. The block updates its
  // registers with nonblocking assignments, so the values seen here are the
  // ones that were present at the edge. A character word is noted before the
  // result word of the same edge is checked, which is harmless because a
  // result always belongs to an older character.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready)
        word_check.set_capacity(cfg_if.output_capacity);
      if (chars_if.valid && chars_if.ready)
        word_check.note_char(chars_if.char_code, chars_if.end_of_message);
      if (bytes_if.valid && bytes_if.ready)
        word_check.check_word('{byte_valid:   bytes_if.byte_valid,
                                data_byte:    bytes_if.data_byte,
                                status:       bytes_if.status,
                                message_done: bytes_if.message_done,
                                byte_count:   bytes_if.byte_count});
    end
  end

  // Receiver side. Ready changes only at the falling edge. Normally it
  // alternates random stalls with random ready stretches; on request it holds
  // off for a long stretch so that both internal registers fill and the
  // character input stalls; in the final part it stays ready.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned run_left;
    hold_left  = 0;
    stall_left = 0;
    run_left   = 0;
    bytes_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        bytes_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        bytes_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        bytes_if.ready <= 1'b0;
      end else if (steady) begin
        bytes_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        bytes_if.ready <= 1'b0;
      end else if (run_left != 0) begin
        run_left--;
        bytes_if.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 11);
        bytes_if.ready <= 1'b0;
      end else begin
        run_left = $urandom_range(0, 30);
        bytes_if.ready <= 1'b1;
      end
    end
  end

  // The watchdog ends the run when no word moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (chars_if.valid && chars_if.ready) || (bytes_if.valid && bytes_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] Timeout: no word moved for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, word_check.expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // All driving tasks start and end at a falling edge. A character word keeps
  // valid high when the next word follows at once, so valid is never lowered
  // and raised within the same time step.
  task automatic send_char(input logic [CharW-1:0] ch, input logic last);
    chars_if.valid          <= 1'b1;
    chars_if.char_code      <= ch;
    chars_if.end_of_message <= last;
    do @(posedge clk); while (!chars_if.ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic char_gap(input int unsigned cycles);
    chars_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Random sender idling: bursts of empty cycles between runs of back-to-back
  // words, and none at all in the steady part.
  task automatic maybe_gap();
    if (steady) return;
    if (tx_run_left != 0) begin
      tx_run_left--;
    end else begin
      if ($urandom_range(0, 2) == 0) char_gap($urandom_range(1, 12));
      tx_run_left = $urandom_range(0, 30);
    end
  endtask

  // Stops offering characters until every predicted word has come out.
  // It always waits for a later falling edge, so a following task starts in a
  // fresh time step.
  task automatic drain();
    chars_if.valid <= 1'b0;
    do @(negedge clk); while (word_check.expected_words.size() != 0);
  endtask

  // Capacity writes happen only with the block idle. The message state is
  // kept across the write, so a write between two characters of one message
  // changes the limit in the middle of that message.
  task automatic write_capacity(input logic [CountW-1:0] value);
    drain();
    cfg_if.valid           <= 1'b1;
    cfg_if.output_capacity <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CountW-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CAP_RESET;
      2:       return CountW'($urandom_range(0, 65535));
      default: return CountW'($urandom_range(1, 24));
    endcase
  endfunction

  // Mostly alphabet symbols, with both spellings of 62 and 63, and a share of
  // padding and whitespace that the decoder skips, and of arbitrary codes.
  function automatic logic [CharW-1:0] pick_char();
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (r < 84) begin
      idx = $urandom_range(0, 63);
      if (idx < 26) return CH_UPPER_A + CharW'(idx);
      if (idx < 52) return CH_LOWER_A + CharW'(idx - 26);
      if (idx < 62) return CH_DIGIT_0 + CharW'(idx - 52);
      if (idx == 62) return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      return $urandom_range(0, 1) ? CH_SLASH : CH_UNDER;
    end
    if (r < 90) return CH_PAD;
    if (r < 94) begin
      case ($urandom_range(0, 3))
        0:       return CH_SPACE;
        1:       return CH_TAB;
        2:       return CH_LF;
        default: return CH_CR;
      endcase
    end
    return CharW'($urandom_range(0, 255));
  endfunction

  // Main stimulus: reset, a directed part, then random phases.
  initial begin
    int unsigned target;
    int unsigned phase;
    int unsigned msg_count;
    int unsigned len;
    int unsigned hold_done;
    logic        last;

    rst                    = 1'b1;
    chars_if.valid         = 1'b0;
    chars_if.char_code     = '0;
    chars_if.end_of_message = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.output_capacity = '0;
    hold_done              = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset capacity. First the edges of
    // every alphabet range and both spellings of 62 and 63, then skipped
    // codes at both ends of the byte range, padding and whitespace. The
    // message ends on a skipped character with bits still pending.
    send_char(CH_UPPER_A, 1'b0);
    send_char(CH_UPPER_Z, 1'b0);
    send_char(CH_LOWER_A, 1'b0);
    send_char(CH_LOWER_Z, 1'b0);
    send_char(CH_DIGIT_0, 1'b0);
    send_char(CH_DIGIT_9, 1'b0);
    send_char(CH_PLUS, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_SLASH, 1'b0);
    send_char(CH_UNDER, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_PAD, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(8'h80, 1'b1);

    // A zero capacity drops the very first byte of the message.
    write_capacity('0);
    send_char("T", 1'b0);
    send_char("W", 1'b0);
    send_char("F", 1'b0);
    send_char("u", 1'b1);

    // The limit is reached after one byte, and raising it afterwards in the
    // same message does not bring the later bytes back.
    write_capacity(16'd1);
    send_char("T", 1'b0);
    send_char("W", 1'b0);
    send_char("F", 1'b0);
    write_capacity(CAP_RESET);
    send_char("u", 1'b1);

    // Raising the limit before it is hit lets one more byte through: each
    // byte is compared with the register value of its own word.
    write_capacity(16'd1);
    send_char("T", 1'b0);
    send_char("W", 1'b0);
    write_capacity(16'd2);
    send_char("F", 1'b0);
    send_char("u", 1'b1);

    // Random phases. Each phase sets a new capacity and sends a few messages
    // of random length; some messages get a capacity change halfway, a few
    // characters carry a stray end mark to break a message early.
    target = chars_sent + RANDOM_CHARS;
    phase  = 0;
    while (chars_sent < target) begin
      write_capacity(pick_capacity());
      msg_count = $urandom_range(1, 4);
      for (int m = 0; m < msg_count && chars_sent < target; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 28);
        if (phase == 3 && hold_done == 0) begin
          // The receiver holds off while characters keep coming without
          // gaps, so the block fills up and stalls its input.
          hold_done = 1;
          len       = 24;
          hold_req  = 1'b1;
          for (int i = 0; i < len; i++)
            send_char(pick_char(), i == len - 1);
        end else begin
          for (int i = 0; i < len; i++) begin
            if (len > 3 && i == len / 2 && $urandom_range(0, 7) == 0)
              write_capacity(pick_capacity());
            maybe_gap();
            last = (i == len - 1) || ($urandom_range(0, 39) == 0);
            send_char(pick_char(), last);
          end
        end
        if (chars_sent + STEADY_TAIL >= target) steady = 1'b1;
      end
      phase++;
    end

    // Wait for every result, then give the pipeline a few more cycles to
    // show any word that should not be there.
    drain();
    repeat (10) @(negedge clk);
    if (word_check.expected_words.size() != 0)
      word_check.report("results still outstanding", word_check.expected_words.size(), 0);

    $display("Checked %0d result words from %0d characters over %0d complete messages.",
             word_check.words_checked, chars_sent, word_check.messages);
    $display("Saw %0d decoded bytes, %0d words in overflow, %0d capacity writes, %0d errors.",
             word_check.bytes_decoded, word_check.overflow_words, word_check.cap_writes,
             word_check.errors);
    if (word_check.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_sym_map.sv
rtl/b64d_accum.sv
rtl/base64_stream_decoder_unit.sv
tb/tb.sv
